// ----- design/rstpb_pkg.sv -----
// Shared types, constants and checksum helper for the TCP reset reply builder.
package rstpb_pkg;

  localparam int FrameWords = 27;
  localparam int WordW      = 16;
  localparam int IdxW       = $clog2(FrameWords);
  localparam int InDataW    = 264;

  localparam logic [IdxW-1:0]  LastIdx     = IdxW'(FrameWords - 1);
  localparam logic [7:0]       TtlReset    = 8'd128;
  localparam int               RstFlagBit  = 2;
  localparam logic [7:0]       IpVerIhl    = 8'h45;
  localparam logic [15:0]      IpTotalLen  = 16'd40;
  localparam logic [7:0]       IpProtoTcp  = 8'd6;
  localparam logic [15:0]      TcpLen      = 16'd20;
  localparam logic [15:0]      TcpOffFlags = 16'h5014;

  typedef logic [FrameWords-1:0][WordW-1:0] frame_t;

  // Packed so that the last member sits in the lowest bits of s_tdata.
  typedef struct packed {
    logic [6:0]  pad;
    logic [7:0]  tcp_flag_bits;
    logic [31:0] seq_num;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [7:0]  service_type;
    logic [31:0] ip_dest;
    logic [31:0] ip_source;
    logic [15:0] ether_kind;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic        deny;
  } seg_t;

  // Ones' complement fold of a sum of at most sixteen 16-bit words.
  function automatic logic [15:0] ones_fold(input logic [19:0] sum);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
    s2 = s1[15:0] + {15'd0, s1[16]};
    return ~s2;
  endfunction

endpackage

// ----- design/rstpb_build.sv -----
// Builds the 27-word reset reply image with both checksums from one segment.
module rstpb_build (
  input  rstpb_pkg::seg_t   seg,
  input  logic [7:0]        ttl,
  output rstpb_pkg::frame_t image
);

  logic [31:0] ack;
  logic [19:0] tcp_sum;
  logic [19:0] ip_sum;
  logic [15:0] ttl_proto;
  logic [15:0] ver_tos;

  assign ack       = seg.seq_num + 32'd1;
  assign ttl_proto = {ttl, rstpb_pkg::IpProtoTcp};
  assign ver_tos   = {rstpb_pkg::IpVerIhl, seg.service_type};

  // pseudo header plus TCP header, zero words left out
  assign tcp_sum = 20'(seg.ip_dest[31:16]) + 20'(seg.ip_dest[15:0])
                 + 20'(seg.ip_source[31:16]) + 20'(seg.ip_source[15:0])
                 + 20'(rstpb_pkg::IpProtoTcp) + 20'(rstpb_pkg::TcpLen)
                 + 20'(seg.dst_port) + 20'(seg.src_port)
                 + 20'(ack[31:16]) + 20'(ack[15:0])
                 + 20'(rstpb_pkg::TcpOffFlags);

  assign ip_sum = 20'(ver_tos) + 20'(rstpb_pkg::IpTotalLen) + 20'(ttl_proto)
                + 20'(seg.ip_dest[31:16]) + 20'(seg.ip_dest[15:0])
                + 20'(seg.ip_source[31:16]) + 20'(seg.ip_source[15:0]);

  always_comb begin
    image     = '0;
    image[0]  = seg.src_mac[47:32];
    image[1]  = seg.src_mac[31:16];
    image[2]  = seg.src_mac[15:0];
    image[3]  = seg.dst_mac[47:32];
    image[4]  = seg.dst_mac[31:16];
    image[5]  = seg.dst_mac[15:0];
    image[6]  = seg.ether_kind;
    image[7]  = ver_tos;
    image[8]  = rstpb_pkg::IpTotalLen;
    image[11] = ttl_proto;
    image[12] = rstpb_pkg::ones_fold(ip_sum);
    image[13] = seg.ip_dest[31:16];
    image[14] = seg.ip_dest[15:0];
    image[15] = seg.ip_source[31:16];
    image[16] = seg.ip_source[15:0];
    image[17] = seg.dst_port;
    image[18] = seg.src_port;
    image[21] = ack[31:16];
    image[22] = ack[15:0];
    image[23] = rstpb_pkg::TcpOffFlags;
    image[25] = rstpb_pkg::ones_fold(tcp_sum);
  end

endmodule

// ----- design/rstpb_emit.sv -----
// Frame register and word sequencer driving the output stream.
module rstpb_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  rstpb_pkg::frame_t          image,
  output logic                       free,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rstpb_pkg::WordW-1:0] m_tdata, // packet_word
  output logic                       m_tlast   // last_word
);

  rstpb_pkg::frame_t           frame;
  logic [rstpb_pkg::IdxW-1:0]  idx;
  logic                        emitting;
  logic                        xfer;
  logic                        last_xfer;

  assign xfer      = emitting && m_tready;
  assign last_xfer = xfer && (idx == rstpb_pkg::LastIdx);
  assign free      = !emitting || last_xfer;

  assign m_tvalid = emitting;
  assign m_tdata  = frame[idx];
  assign m_tlast  = emitting && (idx == rstpb_pkg::LastIdx);

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= image;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitting <= 1'b0;
      idx      <= '0;
    end else if (load) begin
      emitting <= 1'b1;
      idx      <= '0;
    end else if (last_xfer) begin
      emitting <= 1'b0;
      idx      <= '0;
    end else if (xfer) begin
      idx <= idx + 1'b1;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= rstpb_pkg::LastIdx)
    else $error("word index beyond frame");

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !emitting |-> idx == '0)
    else $error("index not parked while idle");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("frame reloaded mid-reply");

  a_word_step: assert property (@(posedge clk) disable iff (rst)
    (xfer && !m_tlast && !load) |=> idx == $past(idx) + 1'b1)
    else $error("word index skipped");

endmodule

// ----- design/tcp_reset_packet_builder.sv -----
// Top level of the TCP reset reply builder: request register, TTL register, build and emit.
// With the emitter free, an accepted request passes from the request register into the frame
// register of the emitter, and the first reply word is then valid on m_tdata.
// A reply streams out one word per cycle while m_tready is high, set by the single word
// output; the next request is taken while the current reply streams out.
// Requests that are not denied, or that carry the reset flag, are dropped at one a cycle
// while s_tready is high.
// Reset (rst, synchronous): stream idle, TTL register back to 128.
module tcp_reset_packet_builder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // deny, src_mac, dst_mac, ether_kind, ip_source, ip_dest, service_type,
  // src_port, dst_port, seq_num, tcp_flag_bits, zero pad
  input  logic [rstpb_pkg::InDataW-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rstpb_pkg::WordW-1:0]    m_tdata, // packet_word
  output logic                           m_tlast, // last_word
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [7:0]                     cfg_data // reply_ttl
);

  rstpb_pkg::seg_t   seg_in;
  rstpb_pkg::seg_t   seg;
  rstpb_pkg::frame_t image;
  logic              seg_valid;
  logic              wanted;
  logic              load;
  logic              free;
  logic [7:0]        ttl;

  assign seg_in    = rstpb_pkg::seg_t'(s_tdata);
  assign wanted    = seg_in.deny && !seg_in.tcp_flag_bits[rstpb_pkg::RstFlagBit];
  assign load      = seg_valid && free;
  assign s_tready  = !seg_valid || free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl <= rstpb_pkg::TtlReset;
    end else if (cfg_valid) begin
      ttl <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (s_tvalid && s_tready && wanted) begin
      seg_valid <= 1'b1;
    end else if (load) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && wanted) begin
      seg <= seg_in;
    end
  end

  rstpb_build u_build (
    .seg   (seg),
    .ttl   (ttl),
    .image (image)
  );

  rstpb_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .image    (image),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- test/tcp_reset_packet_builder_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for tcp_reset_packet_builder: segments in, replies scored per word.
module tcp_reset_packet_builder_tb;

  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 600;

  typedef struct {
    logic [15:0] word;
    logic        last;
  } reply_word_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [rstpb_pkg::InDataW-1:0] s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [rstpb_pkg::WordW-1:0]   m_tdata;
  logic                          m_tlast;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [7:0]                    cfg_data = '0;

  rstpb_pkg::seg_t seg_backlog[$];
  reply_word_t     reply_words[$];
  logic [7:0]      ttl_shadow = rstpb_pkg::TtlReset;
  int              tx_idle_pct = 0;
  int              rx_stall_pct = 0;
  bit              seg_hs = 1'b0;
  bit              hold_go = 1'b0;
  bit              rx_hold = 1'b0;
  int              errors = 0;
  int              segs_taken = 0;
  int              replies_built = 0;
  int              segs_dropped = 0;
  int              words_seen = 0;
  int              cycles = 0;

  tcp_reset_packet_builder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] csum_fold(logic [31:0] acc);
    while (acc[31:16] != 16'd0) acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  // raw sum of the reply IP header, checksum word taken as zero
  function automatic logic [31:0] ip_hdr_sum(rstpb_pkg::seg_t s, logic [7:0] ttl);
    logic [31:0] acc;
    acc = 32'({rstpb_pkg::IpVerIhl, s.service_type});
    acc = acc + 32'(rstpb_pkg::IpTotalLen) + 32'({ttl, rstpb_pkg::IpProtoTcp});
    acc = acc + 32'(s.ip_dest[31:16]) + 32'(s.ip_dest[15:0]);
    acc = acc + 32'(s.ip_source[31:16]) + 32'(s.ip_source[15:0]);
    return acc;
  endfunction

  // raw sum of pseudo header and reply TCP header, checksum word taken as zero
  function automatic logic [31:0] tcp_sum(rstpb_pkg::seg_t s);
    logic [31:0] acc;
    logic [31:0] ack;
    ack = s.seq_num + 32'd1;
    acc = 32'(s.ip_dest[31:16]);
    acc = acc + 32'(s.ip_dest[15:0]);
    acc = acc + 32'(s.ip_source[31:16]) + 32'(s.ip_source[15:0]);
    acc = acc + 32'(rstpb_pkg::IpProtoTcp) + 32'(rstpb_pkg::TcpLen);
    acc = acc + 32'(s.dst_port) + 32'(s.src_port);
    acc = acc + 32'(ack[31:16]) + 32'(ack[15:0]) + 32'(rstpb_pkg::TcpOffFlags);
    return acc;
  endfunction

  function automatic bit is_answered(rstpb_pkg::seg_t s);
    return s.deny && !s.tcp_flag_bits[rstpb_pkg::RstFlagBit];
  endfunction

  function automatic void predict_reply(rstpb_pkg::seg_t s);
    logic [15:0] img [rstpb_pkg::FrameWords];
    logic [31:0] ack;
    ack = s.seq_num + 32'd1;
    img[0]  = s.src_mac[47:32];
    img[1]  = s.src_mac[31:16];
    img[2]  = s.src_mac[15:0];
    img[3]  = s.dst_mac[47:32];
    img[4]  = s.dst_mac[31:16];
    img[5]  = s.dst_mac[15:0];
    img[6]  = s.ether_kind;
    img[7]  = {rstpb_pkg::IpVerIhl, s.service_type};
    img[8]  = rstpb_pkg::IpTotalLen;
    img[9]  = 16'd0;
    img[10] = 16'd0;
    img[11] = {ttl_shadow, rstpb_pkg::IpProtoTcp};
    img[12] = csum_fold(ip_hdr_sum(s, ttl_shadow));
    img[13] = s.ip_dest[31:16];
    img[14] = s.ip_dest[15:0];
    img[15] = s.ip_source[31:16];
    img[16] = s.ip_source[15:0];
    img[17] = s.dst_port;
    img[18] = s.src_port;
    img[19] = 16'd0;
    img[20] = 16'd0;
    img[21] = ack[31:16];
    img[22] = ack[15:0];
    img[23] = rstpb_pkg::TcpOffFlags;
    img[24] = 16'd0;
    img[25] = csum_fold(tcp_sum(s));
    img[26] = 16'd0;
    for (int i = 0; i < rstpb_pkg::FrameWords; i++)
      reply_words.push_back('{img[i], i == rstpb_pkg::FrameWords - 1});
  endfunction

  function automatic rstpb_pkg::seg_t random_segment(bit answered);
    rstpb_pkg::seg_t s;
    s = '0;
    s.src_mac       = 48'({$urandom(), $urandom()});
    s.dst_mac       = 48'({$urandom(), $urandom()});
    s.ether_kind    = 16'($urandom());
    s.ip_source     = $urandom();
    s.ip_dest       = $urandom();
    s.service_type  = 8'($urandom());
    s.src_port      = 16'($urandom());
    s.dst_port      = 16'($urandom());
    s.seq_num       = ($urandom_range(9) == 0) ? '1 : $urandom();
    s.tcp_flag_bits = 8'($urandom());
    s.deny          = 1'($urandom_range(1));
    if (answered) begin
      s.deny = 1'b1;
      s.tcp_flag_bits[rstpb_pkg::RstFlagBit] = 1'b0;
    end
    return s;
  endfunction

  // sender
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || seg_hs) begin
      if (seg_hs) void'(seg_backlog.pop_front());
      if (seg_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata  <= seg_backlog[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    m_tready <= !rst && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // long receiver hold-off so the block backs up onto its input
  initial begin
    wait (hold_go);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin : score
    reply_word_t want;
    seg_hs = s_tvalid && s_tready;
    if (!rst) begin
      if (seg_hs) begin
        segs_taken++;
        if (is_answered(rstpb_pkg::seg_t'(s_tdata))) begin
          replies_built++;
          predict_reply(rstpb_pkg::seg_t'(s_tdata));
        end else begin
          segs_dropped++;
        end
      end
      if (m_tvalid && m_tready) begin
        words_seen++;
        if (reply_words.size() == 0) begin
          $error("packet_word: expected none, actual %h", m_tdata);
          errors++;
        end else begin
          want = reply_words.pop_front();
          if (m_tdata !== want.word) begin
            $error("packet_word: expected %h, actual %h", want.word, m_tdata);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last_word: expected %b, actual %b", want.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic drain();
    do @(posedge clk);
    while (seg_backlog.size() != 0 || s_tvalid || reply_words.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ttl(logic [7:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    ttl_shadow = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int tx, int rx, int replies, bit squeeze);
    int              made;
    rstpb_pkg::seg_t s;
    made = 0;
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    if (squeeze) hold_go = 1'b1;
    while (made < replies) begin
      s = random_segment($urandom_range(99) < 80);
      if (is_answered(s)) made++;
      seg_backlog.push_back(s);
    end
    drain();
  endtask

  initial begin
    rstpb_pkg::seg_t s;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, TTL at its reset value
    s = '0;
    s.deny = 1'b1;
    seg_backlog.push_back(s);
    s = '1;
    s.pad = '0;
    s.tcp_flag_bits[rstpb_pkg::RstFlagBit] = 1'b0; // all ones, ack wraps to zero
    seg_backlog.push_back(s);
    s.deny = 1'b0;                                  // not denied
    seg_backlog.push_back(s);
    s = '0;
    s.deny = 1'b1;
    s.tcp_flag_bits[rstpb_pkg::RstFlagBit] = 1'b1; // segment is itself a reset
    seg_backlog.push_back(s);
    s = '1;
    s.pad = '0;
    seg_backlog.push_back(s);
    s = {33{8'hAA}};
    s.pad = '0;
    s.deny = 1'b1;
    s.tcp_flag_bits[rstpb_pkg::RstFlagBit] = 1'b0;
    seg_backlog.push_back(s);
    s = {33{8'h55}};
    s.pad = '0;
    s.tcp_flag_bits[rstpb_pkg::RstFlagBit] = 1'b0;
    seg_backlog.push_back(s);
    // both checksums come out as zero
    s = random_segment(1'b1);
    s.ip_source[15:0] = 16'd0;
    s.ip_source[15:0] = csum_fold(ip_hdr_sum(s, ttl_shadow));
    s.src_port = 16'd0;
    s.src_port = csum_fold(tcp_sum(s));
    seg_backlog.push_back(s);
    repeat (8) seg_backlog.push_back(random_segment(1'($urandom_range(1))));
    drain();

    write_ttl(8'd0);
    random_phase(77, 0, 28, 1'b0);
    write_ttl(8'd255);
    random_phase(0, 77, 28, 1'b0);
    write_ttl(8'($urandom_range(1, 254)));
    random_phase(12, 12, 28, 1'b0);
    write_ttl(8'd1);
    random_phase(0, 0, 16, 1'b1);

    $display("Segments taken %0d: %0d answered with reset replies (%0d words), %0d dropped.",
             segs_taken, replies_built, words_seen, segs_dropped);
    $display("TTL 128, 0, 255, random and 1; idle, stall and long hold-off phases run.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/rstpb_pkg.sv
design/rstpb_build.sv
design/rstpb_emit.sv
design/tcp_reset_packet_builder.sv
test/tcp_reset_packet_builder_tb.sv
